// ===== hw/rtl/timed_task_dispatch_queue_assert.svh =====
// assertion macros for the timed task dispatch queue
`ifndef TIMED_TASK_DISPATCH_QUEUE_ASSERT_SVH
`define TIMED_TASK_DISPATCH_QUEUE_ASSERT_SVH

// consequent must hold in the same cycle
`define TTDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define TTDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ttdq_pkg.sv =====
// shared constants, codes and control types for the timed task dispatch queue
package ttdq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int TIMER_SLOTS = 8;
  localparam int ID_BITS     = 8;
  localparam int PARAM_BITS  = 16;
  localparam int DELAY_BITS  = 16;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int ACNT_W = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_POST = 2'd0,
    CMD_ARM  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_TAKE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARM_SCAN,
    ST_ARM_FILL,
    ST_TICK_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic push_in;
    logic take;
    logic load;
    logic arm_step;
    logic arm_fill;
    logic tick_step;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic delay_zero;
    logic armed_full;
    logic armed_empty;
    logic hit;
    logic idx_last;
  } stat_t;

endpackage

// ===== hw/rtl/timed_task_dispatch_queue.sv =====
// post, take: never busy; take result appears on done in the cycle after acceptance
// arm with nonzero delay and a free slot: busy for a slot scan (one slot per cycle)
// and a fill step, ending early on an armed id match; tick: busy for a scan of every slot
// arm and tick throughput is set by the one-slot-per-cycle scan; results cannot be stalled
// synchronous reset empties the fifo and frees every timer slot at once, no clearing pass
// fifo entry contents are not reset and are only read after being written
module timed_task_dispatch_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [ttdq_pkg::ID_BITS-1:0]    task_id,
  input  logic [ttdq_pkg::PARAM_BITS-1:0] task_param,
  input  logic [ttdq_pkg::DELAY_BITS-1:0] delay_ticks,
  output logic                            done,
  output logic [ttdq_pkg::ID_BITS-1:0]    ready_task_id,
  output logic [ttdq_pkg::PARAM_BITS-1:0] ready_param,
  output logic                            queue_was_empty
);

  `include "timed_task_dispatch_queue_assert.svh"

  ttdq_pkg::ctl_t  ctl;
  ttdq_pkg::stat_t stat;

  logic take_word, post_word, idle_zero;

  ttdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  ttdq_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .task_id         (task_id),
    .task_param      (task_param),
    .delay_ticks     (delay_ticks),
    .stat            (stat),
    .done            (done),
    .ready_task_id   (ready_task_id),
    .ready_param     (ready_param),
    .queue_was_empty (queue_was_empty)
  );

  assign take_word = start && !busy && (command == ttdq_pkg::CMD_TAKE);
  assign post_word = start && !busy && (command == ttdq_pkg::CMD_POST);
  assign idle_zero = (ready_task_id == '0) && (ready_param == '0);

  // a take word always gives exactly one result on the next cycle
  `TTDQ_ASSERT_NEXT(a_take_done, take_word, done, "take gave no result")
  `TTDQ_ASSERT_NEXT(a_no_spurious, !take_word, !done, "result without take")
  `TTDQ_ASSERT_NOW(a_idle_task, done && queue_was_empty, idle_zero, "idle result not zero")
  `TTDQ_ASSERT_NEXT(a_post_quick, post_word, !busy, "post left block busy")

endmodule

// ===== hw/rtl/ttdq_ctrl.sv =====
// command sequencer for the timed task dispatch queue
module ttdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      command,
  input  ttdq_pkg::stat_t stat,
  output ttdq_pkg::ctl_t  ctl,
  output logic            busy
);

  ttdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      ttdq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (ttdq_pkg::cmd_t'(command))
            ttdq_pkg::CMD_POST: ctl.push_in = 1'b1;
            ttdq_pkg::CMD_TAKE: ctl.take = 1'b1;
            ttdq_pkg::CMD_ARM: begin
              if (stat.delay_zero) begin
                ctl.push_in = 1'b1;
              end else if (!stat.armed_full) begin
                ctl.load   = 1'b1;
                state_next = ttdq_pkg::ST_ARM_SCAN;
              end
            end
            ttdq_pkg::CMD_TICK: begin
              if (!stat.armed_empty) begin
                ctl.load   = 1'b1;
                state_next = ttdq_pkg::ST_TICK_SCAN;
              end
            end
          endcase
        end
      end
      ttdq_pkg::ST_ARM_SCAN: begin
        ctl.arm_step = 1'b1;
        if (stat.hit) begin
          state_next = ttdq_pkg::ST_IDLE;
        end else if (stat.idx_last) begin
          state_next = ttdq_pkg::ST_ARM_FILL;
        end
      end
      ttdq_pkg::ST_ARM_FILL: begin
        ctl.arm_fill = 1'b1;
        state_next   = ttdq_pkg::ST_IDLE;
      end
      ttdq_pkg::ST_TICK_SCAN: begin
        ctl.tick_step = 1'b1;
        if (stat.idx_last) begin
          state_next = ttdq_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/ttdq_datapath.sv =====
// ready fifo, timer slots and result registers
module ttdq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ttdq_pkg::ctl_t                  ctl,
  input  logic [ttdq_pkg::ID_BITS-1:0]    task_id,
  input  logic [ttdq_pkg::PARAM_BITS-1:0] task_param,
  input  logic [ttdq_pkg::DELAY_BITS-1:0] delay_ticks,
  output ttdq_pkg::stat_t                 stat,
  output logic                            done,
  output logic [ttdq_pkg::ID_BITS-1:0]    ready_task_id,
  output logic [ttdq_pkg::PARAM_BITS-1:0] ready_param,
  output logic                            queue_was_empty
);

  localparam int QW = ttdq_pkg::QPTR_W;
  localparam int CW = ttdq_pkg::QCNT_W;
  localparam int SW = ttdq_pkg::SLOT_W;
  localparam int AW = ttdq_pkg::ACNT_W;
  localparam int DW = ttdq_pkg::DELAY_BITS;

  logic [ttdq_pkg::ID_BITS-1:0]    fifo_id   [ttdq_pkg::QUEUE_DEPTH];
  logic [ttdq_pkg::PARAM_BITS-1:0] fifo_par  [ttdq_pkg::QUEUE_DEPTH];
  logic [ttdq_pkg::ID_BITS-1:0]    slot_task [ttdq_pkg::TIMER_SLOTS];
  logic [ttdq_pkg::PARAM_BITS-1:0] slot_param[ttdq_pkg::TIMER_SLOTS];
  logic [DW-1:0]                   slot_rem  [ttdq_pkg::TIMER_SLOTS];

  logic [QW-1:0] head, tail;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] armed;
  logic [SW-1:0] idx, free_pos;
  logic [ttdq_pkg::ID_BITS-1:0]    lat_id;
  logic [ttdq_pkg::PARAM_BITS-1:0] lat_param;
  logic [DW-1:0]                   lat_delay;

  logic [DW-1:0]                   cur_rem;
  logic                            expire;
  logic                            push_en, push_ok, pop_ok, q_empty;
  logic [ttdq_pkg::ID_BITS-1:0]    push_id;
  logic [ttdq_pkg::PARAM_BITS-1:0] push_par;

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
    return (p == QW'(ttdq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  always_comb begin
    cur_rem  = slot_rem[idx];
    expire   = ctl.tick_step && (cur_rem == DW'(1));
    q_empty  = (count == '0);
    push_en  = ctl.push_in || expire;
    push_id  = ctl.push_in ? task_id : slot_task[idx];
    push_par = ctl.push_in ? task_param : slot_param[idx];
    push_ok  = push_en && (count != CW'(ttdq_pkg::QUEUE_DEPTH));
    pop_ok   = ctl.take && !q_empty;
    if (push_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
    stat.delay_zero  = (delay_ticks == '0);
    stat.armed_full  = (armed == AW'(ttdq_pkg::TIMER_SLOTS));
    stat.armed_empty = (armed == '0);
    stat.hit         = (cur_rem != '0) && (slot_task[idx] == lat_id);
    stat.idx_last    = (idx == SW'(ttdq_pkg::TIMER_SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      armed <= '0;
      idx   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < ttdq_pkg::TIMER_SLOTS; i++) begin
        slot_rem[i] <= '0;
      end
    end else begin
      done  <= ctl.take;
      count <= count_next;
      if (push_ok) begin
        tail <= wrap_inc(tail);
      end
      if (pop_ok) begin
        head <= wrap_inc(head);
      end
      if (ctl.load) begin
        idx <= '0;
      end else if (ctl.arm_step || ctl.tick_step) begin
        idx <= idx + SW'(1);
      end
      // a matching armed slot only gets its time replaced
      if (ctl.arm_step && stat.hit) begin
        slot_rem[idx] <= lat_delay;
      end
      if (ctl.arm_fill) begin
        slot_rem[free_pos] <= lat_delay;
        armed              <= armed + AW'(1);
      end
      if (expire) begin
        slot_rem[idx] <= '0;
        armed         <= armed - AW'(1);
      end else if (ctl.tick_step && (cur_rem != '0)) begin
        slot_rem[idx] <= cur_rem - DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lat_id    <= task_id;
      lat_param <= task_param;
      lat_delay <= delay_ticks;
    end
    // last free slot seen is the highest-indexed one
    if (ctl.arm_step && (cur_rem == '0)) begin
      free_pos <= idx;
    end
    if (push_ok) begin
      fifo_id[tail]  <= push_id;
      fifo_par[tail] <= push_par;
    end
    if (ctl.arm_fill) begin
      slot_task[free_pos]  <= lat_id;
      slot_param[free_pos] <= lat_param;
    end
    if (ctl.take) begin
      if (q_empty) begin
        ready_task_id   <= '0;
        ready_param     <= '0;
        queue_was_empty <= 1'b1;
      end else begin
        ready_task_id   <= fifo_id[head];
        ready_param     <= fifo_par[head];
        queue_was_empty <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the timed task dispatch queue: ready fifo and timer slots
module tb_top;
  import ttdq_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_WORDS  = 1830;
  localparam int CALM_WORDS    = 150;
  localparam int BLOCK_WORDS   = 64;
  localparam int SETTLE_CYCLES = 2 * TIMER_SLOTS + 6;
  localparam int RUN_LIMIT     = 5_000_000;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [PARAM_BITS-1:0] par;
    logic                  was_empty;
  } taken_task_t;

  typedef struct {
    cmd_t                  op;
    logic [ID_BITS-1:0]    id;
    logic [PARAM_BITS-1:0] par;
    logic [DELAY_BITS-1:0] delay;
    bit                    wait_drained;
    bit                    idle_after;
  } cmd_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            command = CMD_POST;
  logic [ID_BITS-1:0]    task_id = '0;
  logic [PARAM_BITS-1:0] task_param = '0;
  logic [DELAY_BITS-1:0] delay_ticks = '0;
  logic                  done;
  logic [ID_BITS-1:0]    ready_task_id;
  logic [PARAM_BITS-1:0] ready_param;
  logic                  queue_was_empty;

  timed_task_dispatch_queue dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .task_id         (task_id),
    .task_param      (task_param),
    .delay_ticks     (delay_ticks),
    .done            (done),
    .ready_task_id   (ready_task_id),
    .ready_param     (ready_param),
    .queue_was_empty (queue_was_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the block
  logic [ID_BITS-1:0]    ready_ids  [QUEUE_DEPTH];
  logic [PARAM_BITS-1:0] ready_pars [QUEUE_DEPTH];
  int                    ready_head, ready_tail, ready_count;
  logic [ID_BITS-1:0]    slot_task  [TIMER_SLOTS];
  logic [PARAM_BITS-1:0] slot_par   [TIMER_SLOTS];
  logic [DELAY_BITS-1:0] slot_left  [TIMER_SLOTS];
  int                    armed_count;

  taken_task_t taken_expect[$];
  cmd_word_t   pending_words[$];
  int          mismatch_count = 0;

  function automatic void dispatch_clear();
    ready_head  = 0;
    ready_tail  = 0;
    ready_count = 0;
    armed_count = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ready_ids[i]  = '0;
      ready_pars[i] = '0;
    end
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      slot_task[i] = '0;
      slot_par[i]  = '0;
      slot_left[i] = '0;
    end
  endfunction

  function automatic void ready_push(input logic [ID_BITS-1:0] id,
                                     input logic [PARAM_BITS-1:0] par);
    if (ready_count >= QUEUE_DEPTH) return;
    ready_ids[ready_tail]  = id;
    ready_pars[ready_tail] = par;
    ready_tail = (ready_tail == QUEUE_DEPTH - 1) ? 0 : ready_tail + 1;
    ready_count++;
  endfunction

  function automatic void dispatch_predict(input cmd_t op, input logic [ID_BITS-1:0] id,
                                           input logic [PARAM_BITS-1:0] par,
                                           input logic [DELAY_BITS-1:0] delay);
    int          free_slot;
    taken_task_t want;
    free_slot = -1;
    case (op)
      CMD_POST: begin
        ready_push(id, par);
      end
      CMD_ARM: begin
        if (delay == 0) begin
          ready_push(id, par);
          return;
        end
        // a full slot set drops the request even when the id is already armed
        if (armed_count >= TIMER_SLOTS) return;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_left[i] != 0) begin
            if (slot_task[i] == id) begin
              slot_left[i] = delay;
              return;
            end
          end else begin
            free_slot = i;
          end
        end
        if (free_slot < 0) return;
        slot_task[free_slot] = id;
        slot_par[free_slot]  = par;
        slot_left[free_slot] = delay;
        armed_count++;
      end
      CMD_TICK: begin
        if (armed_count == 0) return;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_left[i] == 1) begin
            ready_push(slot_task[i], slot_par[i]);
            slot_task[i] = '0;
            slot_par[i]  = '0;
            slot_left[i] = '0;
            armed_count--;
          end else if (slot_left[i] != 0) begin
            slot_left[i] = slot_left[i] - 1'b1;
          end
        end
      end
      default: begin
        if (ready_count == 0) begin
          want.id        = '0;
          want.par       = '0;
          want.was_empty = 1'b1;
        end else begin
          want.id        = ready_ids[ready_head];
          want.par       = ready_pars[ready_head];
          want.was_empty = 1'b0;
          ready_head = (ready_head == QUEUE_DEPTH - 1) ? 0 : ready_head + 1;
          ready_count--;
        end
        taken_expect.push_back(want);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_word(input cmd_t op, input logic [ID_BITS-1:0] id,
                          input logic [PARAM_BITS-1:0] par,
                          input logic [DELAY_BITS-1:0] delay,
                          input bit wait_drained, input bit idle_after);
    cmd_word_t w;
    w.op           = op;
    w.id           = id;
    w.par          = par;
    w.delay        = delay;
    w.wait_drained = wait_drained;
    w.idle_after   = idle_after;
    pending_words.push_back(w);
  endtask

  // driver: one word per handshake, optional idle burst after each accepted word
  int        gap_left = 0;
  bit        cur_idle_after = 1'b0;
  bit        accepted;
  bit        next_start;
  cmd_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      accepted   = start && !busy;
      next_start = start && !accepted;
      if (!next_start) begin
        if (accepted && cur_idle_after) begin
          gap_left = $urandom_range(0, 15);
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].wait_drained &&
                       (accepted || taken_expect.size() != 0))) begin
          next_word      = pending_words.pop_front();
          command       <= next_word.op;
          task_id       <= next_word.id;
          task_param    <= next_word.par;
          delay_ticks   <= next_word.delay;
          cur_idle_after = next_word.idle_after;
          next_start     = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // monitor: predicts on every accepted word, checks every result strobe
  taken_task_t want;

  always @(posedge clk) begin
    if (rst) begin
      dispatch_clear();
    end else begin
      if (start && !busy)
        dispatch_predict(cmd_t'(command), task_id, task_param, delay_ticks);
      if (done) begin
        if (taken_expect.size() == 0) begin
          report_mismatch("result with no take outstanding");
        end else begin
          want = taken_expect.pop_front();
          if (ready_task_id !== want.id)
            report_mismatch($sformatf("ready_task_id got %0h want %0h",
                                      ready_task_id, want.id));
          if (ready_param !== want.par)
            report_mismatch($sformatf("ready_param got %0h want %0h",
                                      ready_param, want.par));
          if (queue_was_empty !== want.was_empty)
            report_mismatch($sformatf("queue_was_empty got %0b want %0b",
                                      queue_was_empty, want.was_empty));
        end
      end
    end
  end

  int                    mix, idle_mode, roll, word_idx;
  cmd_t                  op;
  logic [ID_BITS-1:0]    id;
  logic [DELAY_BITS-1:0] delay;
  bit                    calm;

  initial begin
    // directed opening
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_POST, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    add_word(CMD_POST, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_ARM,  8'h55, 16'hAAAA, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // tick with nothing armed, issued once the fifo side has settled
    add_word(CMD_TICK, 8'hAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0);
    add_word(CMD_ARM,  8'h01, 16'h1234, 16'hFFFF, 1'b0, 1'b1);
    add_word(CMD_ARM,  8'h02, 16'h5678, 16'h0002, 1'b0, 1'b0);
    // re-arm of a live id keeps its parameter
    add_word(CMD_ARM,  8'h01, 16'h9999, 16'h0001, 1'b0, 1'b0);
    add_word(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1);
    add_word(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // two slots expiring together leave in slot order
    add_word(CMD_ARM,  8'h03, 16'h0303, 16'h0001, 1'b0, 1'b0);
    add_word(CMD_ARM,  8'h04, 16'h0404, 16'h0001, 1'b0, 1'b0);
    add_word(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_word(CMD_TAKE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);

    // random part in blocks that lean towards filling, draining or neither
    mix = 0;
    idle_mode = 0;
    for (word_idx = 0; word_idx < RANDOM_WORDS; word_idx++) begin
      if (word_idx % BLOCK_WORDS == 0) begin
        mix       = $urandom_range(0, 2);
        idle_mode = $urandom_range(0, 2);
      end
      roll = $urandom_range(0, 99);
      case (mix)
        0:       op = (roll < 35) ? CMD_POST : (roll < 70) ? CMD_ARM :
                      (roll < 85) ? CMD_TICK : CMD_TAKE;
        1:       op = (roll < 10) ? CMD_POST : (roll < 30) ? CMD_ARM :
                      (roll < 45) ? CMD_TICK : CMD_TAKE;
        default: op = (roll < 25) ? CMD_POST : (roll < 50) ? CMD_ARM :
                      (roll < 72) ? CMD_TICK : CMD_TAKE;
      endcase
      // a small id pool makes re-arms of live timers common
      id = ($urandom_range(0, 9) < 7) ? ID_BITS'($urandom_range(0, 9)) :
                                        ID_BITS'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        delay = '0;
      end else if (roll < 95) begin
        delay = DELAY_BITS'($urandom_range(1, 6));
      end else if (roll < 98) begin
        delay = DELAY_BITS'($urandom_range(7, 40));
      end else begin
        // long timers only on pooled ids so a later re-arm can bring them back
        delay = DELAY_BITS'($urandom_range(0, 65535));
        id    = ID_BITS'($urandom_range(0, 9));
      end
      calm = (word_idx >= RANDOM_WORDS - CALM_WORDS);
      add_word(op, id, PARAM_BITS'($urandom_range(0, 65535)), delay,
               (word_idx % BLOCK_WORDS == 0) && ($urandom_range(0, 1) == 0),
               !calm && ((idle_mode == 1 && $urandom_range(0, 3) == 0) ||
                         (idle_mode == 2 && $urandom_range(0, 1) == 0)));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (taken_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d words pending, %0d takes outstanding",
             pending_words.size(), taken_expect.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
